// ===== hdl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  // Default sizing of the allocator.
  localparam int unsigned DEF_MEM_BYTES    = 524288;
  localparam int unsigned DEF_HEADER_BYTES = 256;
  localparam int unsigned DEF_SLOTS        = 16;
  localparam int unsigned DEF_BLOCK_ALIGN  = 8;

  // Field widths of a transaction.
  localparam int unsigned SIZE_W   = 20;
  localparam int unsigned ALIGN_W  = 8;
  localparam int unsigned OFFS_W   = 20;
  localparam int unsigned GRANT_W  = 19;
  localparam int unsigned STATUS_W = 2;

  // Width of an end address (start plus length).
  localparam int unsigned END_W = SIZE_W + 1;
  // Width of candidate addresses and the sums built from them.
  localparam int unsigned CAND_W = SIZE_W + 2;
  // Slot index field, wide enough for slot tables of up to 64 slots.
  localparam int unsigned SLOT_IDX_W = 6;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_e;

  // Update request from the sequencer to the slot table.
  typedef struct packed {
    logic                  alloc_we;
    logic                  clear_we;
    logic [SLOT_IDX_W-1:0] idx;
  } slot_cmd_t;

endpackage

// ===== hdl/first_fit_region_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit region allocator with a table of allocation slots.
// ----------------------------------------------------------------------------
// Usage: an input transaction (cmd_i, req_size_i, req_align_i, req_offset_i)
// is taken on in_valid_i && in_ready_o; it is either an allocate or a free.
// Each input transaction yields exactly one output transaction (status_o,
// alloc_offset_o) taken on out_valid_o && out_ready_i.
// The block works on one transaction at a time; in_ready_o is high only
// while no transaction is in progress. A free, a rejected request and an
// allocate that finds no free slot go from S_DECODE straight to S_FINISH.
// An allocate that searches jumps past each overlapping region that it
// meets, at most once per live slot and so at most SLOTS - 1 times. Each
// candidate is checked in the parallel slot compare unit (S_CHECK), and
// each jump passes through the rounding multiplier (S_STEP). The next
// transaction can be accepted in the cycle after the result is loaded.
// The output register frees the input side: a new transaction may be taken
// while a result waits; a finished result waits in its own state until the
// output register is free. Reset empties the slot table at once (live bits
// clear) and drops any pending result.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
  parameter int unsigned MEM_BYTES    = ffra_pkg::DEF_MEM_BYTES,
  parameter int unsigned HEADER_BYTES = ffra_pkg::DEF_HEADER_BYTES,
  parameter int unsigned SLOTS        = ffra_pkg::DEF_SLOTS,
  parameter int unsigned BLOCK_ALIGN  = ffra_pkg::DEF_BLOCK_ALIGN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [ffra_pkg::SIZE_W-1:0]    req_size_i,
  input  logic [ffra_pkg::ALIGN_W-1:0]   req_align_i,
  input  logic [ffra_pkg::OFFS_W-1:0]    req_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ffra_pkg::STATUS_W-1:0]  status_o,
  output logic [ffra_pkg::GRANT_W-1:0]   alloc_offset_o
);

  localparam int unsigned IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW     = ffra_pkg::CAND_W;
  localparam int unsigned EW     = ffra_pkg::END_W;
  localparam int unsigned USABLE = (MEM_BYTES > HEADER_BYTES) ? MEM_BYTES - HEADER_BYTES : 0;
  // Reciprocal multiply for the division by BLOCK_ALIGN: exact for CW-bit values.
  localparam int unsigned RL     = (BLOCK_ALIGN > 1) ? $clog2(BLOCK_ALIGN) : 0;
  localparam int unsigned RS     = CW + RL;
  localparam int unsigned PW     = CW + RS + 1;
  localparam logic [RS:0] RECIP  = (RS + 1)'(((64'd1 << RS) + 64'(BLOCK_ALIGN) - 64'd1)
                                   / 64'(BLOCK_ALIGN));

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_STEP,
    S_FINISH
  } state_e;

  state_e                        state_q, state_d;
  logic                          cmd_q, cmd_d;
  logic [ffra_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [ffra_pkg::ALIGN_W-1:0]  align_q, align_d;
  logic [ffra_pkg::OFFS_W-1:0]   offset_q, offset_d;
  logic [IW-1:0]                 slot_q, slot_d;
  logic [CW-1:0]                 step_q, step_d;
  logic [CW-1:0]                 num_q, num_d;
  ffra_pkg::status_e             res_status_q, res_status_d;
  logic [ffra_pkg::GRANT_W-1:0]  res_off_q, res_off_d;
  logic                          out_valid_q, out_valid_d;
  ffra_pkg::status_e             out_status_q, out_status_d;
  logic [ffra_pkg::GRANT_W-1:0]  out_off_q, out_off_d;

  ffra_pkg::slot_cmd_t           slot_cmd;
  logic [CW-1:0]                 cand;
  logic                          hit;
  logic [EW-1:0]                 hit_end;
  logic                          free_any;
  logic [IW-1:0]                 free_idx;
  logic                          match_any;
  logic [IW-1:0]                 match_idx;
  logic                          align_ok;
  logic                          alloc_bad;
  logic                          free_bad;
  logic                          no_fit;
  logic [PW-1:0]                 prod;
  logic                          out_load;

  // Candidate address on the block lattice above the header.
  assign cand = CW'(HEADER_BYTES) + CW'(step_q * CW'(BLOCK_ALIGN));

  // Request checks.
  assign align_ok  = (align_q != '0) && ({1'b0, align_q} <= 9'(BLOCK_ALIGN))
                     && ((align_q & (align_q - 1'b1)) == '0);
  assign alloc_bad = (size_q == '0) || !align_ok || ({1'b0, size_q} > 21'(USABLE));
  assign free_bad  = !align_ok || ({1'b0, offset_q} > 21'(MEM_BYTES))
                     || ({1'b0, size_q} > 21'(MEM_BYTES) - {1'b0, offset_q});
  assign no_fit    = (cand + CW'(size_q)) > CW'(MEM_BYTES);

  // Rounding unit: steps past a blocking end, rounded up to the lattice.
  assign prod = PW'(num_q) * PW'(RECIP);

  ffra_slot_table #(
    .SLOTS(SLOTS)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (slot_cmd),
    .cand_i     (cand),
    .size_i     (size_q),
    .offset_i   (offset_q),
    .hit_o      (hit),
    .hit_end_o  (hit_end),
    .free_o     (free_any),
    .free_idx_o (free_idx),
    .match_o    (match_any),
    .match_idx_o(match_idx)
  );

  assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer next-state and datapath control.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    size_d       = size_q;
    align_d      = align_q;
    offset_d     = offset_q;
    slot_d       = slot_q;
    step_d       = step_q;
    num_d        = num_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    slot_cmd     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          size_d   = req_size_i;
          align_d  = req_align_i;
          offset_d = req_offset_i;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        res_off_d = '0;
        state_d   = S_FINISH;
        if (cmd_q == ffra_pkg::CMD_ALLOC) begin
          if (alloc_bad) begin
            res_status_d = ffra_pkg::ST_INVALID;
          end else if (!free_any) begin
            res_status_d = ffra_pkg::ST_NO_SPACE;
          end else begin
            slot_d  = free_idx;
            step_d  = '0;
            state_d = S_CHECK;
          end
        end else begin
          if (free_bad) begin
            res_status_d = ffra_pkg::ST_INVALID;
          end else if (match_any) begin
            res_status_d      = ffra_pkg::ST_OK;
            slot_cmd.clear_we = 1'b1;
            slot_cmd.idx      = ffra_pkg::SLOT_IDX_W'(match_idx);
          end else begin
            res_status_d = ffra_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_CHECK: begin
        if (no_fit) begin
          res_status_d = ffra_pkg::ST_NO_SPACE;
          res_off_d    = '0;
          state_d      = S_FINISH;
        end else if (!hit) begin
          res_status_d      = ffra_pkg::ST_OK;
          res_off_d         = cand[ffra_pkg::GRANT_W-1:0];
          slot_cmd.alloc_we = 1'b1;
          slot_cmd.idx      = ffra_pkg::SLOT_IDX_W'(slot_q);
          state_d           = S_FINISH;
        end else begin
          num_d   = CW'(hit_end) + CW'(BLOCK_ALIGN - 1) - CW'(HEADER_BYTES);
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        step_d  = prod[RS +: CW];
        state_d = S_CHECK;
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Output register: drained by the receiver, refilled on completion.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_off_d    = res_off_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= ffra_pkg::CMD_ALLOC;
      size_q       <= '0;
      align_q      <= '0;
      offset_q     <= '0;
      slot_q       <= '0;
      step_q       <= '0;
      num_q        <= '0;
      res_status_q <= ffra_pkg::ST_OK;
      res_off_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ffra_pkg::ST_OK;
      out_off_q    <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      size_q       <= size_d;
      align_q      <= align_d;
      offset_q     <= offset_d;
      slot_q       <= slot_d;
      step_q       <= step_d;
      num_q        <= num_d;
      res_status_q <= res_status_d;
      res_off_q    <= res_off_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_off_q    <= out_off_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign alloc_offset_o = out_off_q;

  // Only a successful allocate reports a nonzero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ffra_pkg::ST_OK)) |-> (alloc_offset_o == '0))
    else $error("nonzero offset on a failed transaction");

  // The placement search runs for allocations only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CHECK) || (state_q == S_STEP)) |-> (cmd_q == ffra_pkg::CMD_ALLOC))
    else $error("placement search entered on a free");

  // Each rounding step moves the candidate strictly forward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=> (step_q > $past(step_q)))
    else $error("placement search did not advance");

  // A slot update happens at most once per transaction and never both kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(slot_cmd.alloc_we && slot_cmd.clear_we))
    else $error("conflicting slot updates");

endmodule

// ===== hdl/ffra_slot_table.sv =====
// ----------------------------------------------------------------------------
// ffra_slot_table
// Slot storage with a parallel overlap, free-slot and match compare unit.
// ----------------------------------------------------------------------------
module ffra_slot_table #(
  parameter int unsigned SLOTS = ffra_pkg::DEF_SLOTS,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ffra_pkg::slot_cmd_t              cmd_i,
  input  logic [ffra_pkg::CAND_W-1:0]      cand_i,
  input  logic [ffra_pkg::SIZE_W-1:0]      size_i,
  input  logic [ffra_pkg::OFFS_W-1:0]      offset_i,
  output logic                             hit_o,
  output logic [ffra_pkg::END_W-1:0]       hit_end_o,
  output logic                             free_o,
  output logic [IW-1:0]                    free_idx_o,
  output logic                             match_o,
  output logic [IW-1:0]                    match_idx_o
);

  localparam int unsigned CW = ffra_pkg::CAND_W;

  logic [ffra_pkg::SIZE_W-1:0] start_q [SLOTS];
  logic [ffra_pkg::SIZE_W-1:0] len_q   [SLOTS];
  logic [SLOTS-1:0]            live_q;

  logic [ffra_pkg::END_W-1:0]  end_w [SLOTS];
  logic [SLOTS-1:0]            hit_w;
  logic [SLOTS-1:0]            match_w;
  logic [CW-1:0]               cand_end;
  logic [IW-1:0]               wr_idx;

  assign wr_idx   = cmd_i.idx[IW-1:0];
  assign cand_end = cand_i + CW'(size_i);

  // Live bits are cleared at reset; start and length are valid only while live.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.alloc_we) begin
      live_q[wr_idx] <= 1'b1;
    end else if (cmd_i.clear_we) begin
      live_q[wr_idx] <= 1'b0;
    end
  end

  // Region bounds of a newly granted slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_we) begin
      start_q[wr_idx] <= cand_i[ffra_pkg::SIZE_W-1:0];
      len_q[wr_idx]   <= size_i;
    end
  end

  // Per-slot compares: overlap with the candidate range and exact match.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      end_w[i]   = {1'b0, start_q[i]} + {1'b0, len_q[i]};
      hit_w[i]   = live_q[i] && (cand_i < CW'(end_w[i])) && (CW'(start_q[i]) < cand_end);
      match_w[i] = live_q[i] && (start_q[i] == offset_i) && (len_q[i] == size_i);
    end
  end

  // Priority selection: the lowest-numbered slot wins in each search.
  always_comb begin
    hit_o       = 1'b0;
    hit_end_o   = '0;
    free_o      = 1'b0;
    free_idx_o  = '0;
    match_o     = 1'b0;
    match_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_w[i]) begin
        hit_o     = 1'b1;
        hit_end_o = end_w[i];
      end
      if (!live_q[i]) begin
        free_o     = 1'b1;
        free_idx_o = IW'(i);
      end
      if (match_w[i]) begin
        match_o     = 1'b1;
        match_idx_o = IW'(i);
      end
    end
  end

  // A grant only claims an empty slot, and a free only releases a live one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_we |-> !live_q[wr_idx])
    else $error("allocation overwrites a live slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_we |-> live_q[wr_idx])
    else $error("free releases a slot that is not live");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_we |=> live_q[$past(wr_idx)])
    else $error("granted slot did not become live");

endmodule
